>>> hdl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types, constants and helper functions for the odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

  localparam int CORDIC_STEPS_DEF  = 24;
  localparam int INTERVAL_BITS_DEF = 16;

  localparam logic [15:0] RADIUS_RST = 16'd2376;
  localparam logic [15:0] BASE_RST   = 16'd8913;
  localparam logic [15:0] TICKS_RST  = 16'd2976;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_TICKS  = 2'd2;

  localparam logic [1:0] CMD_RIGHT  = 2'd0;
  localparam logic [1:0] CMD_LEFT   = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // Q4.28 angle constants
  localparam logic signed [31:0] PI_Q28     = 32'sd843314857;
  localparam logic [30:0]        TWO_PI_Q28 = 31'd1686629714;
  localparam logic signed [31:0] GAIN_Q28   = 32'sd163008219;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;

  typedef enum logic [1:0] {
    KIND_RIGHT,
    KIND_LEFT,
    KIND_UPDATE,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] phase;  // {A, B}
  } entry_t;

  typedef struct packed {
    logic [15:0]        left_errors;
    logic [15:0]        right_errors;
    logic [31:0]        left_total;
    logic [31:0]        right_total;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [30:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } result_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_INIT_WAIT,
    S_IDLE,
    S_ENC,
    S_MAG,
    S_MUL,
    S_DDIV,
    S_DDIV_WAIT,
    S_DTH,
    S_DTH_WAIT,
    S_WRAP,
    S_WRAP_WAIT,
    S_COR,
    S_COR_WAIT,
    S_PSC,
    S_PCC,
    S_PSS,
    S_TRIG,
    S_PX,
    S_PY,
    S_ACC,
    S_OUT
  } state_t;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      5'd24: r = 32'sd16;
      5'd25: r = 32'sd8;
      5'd26: r = 32'sd4;
      5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // next phase word along 00,01,11,10
  function automatic logic [1:0] gray_fwd(input logic [1:0] p);
    logic [1:0] r;
    unique case (p)
      2'b00: r = 2'b01;
      2'b01: r = 2'b11;
      2'b11: r = 2'b10;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] gray_bwd(input logic [1:0] p);
    logic [1:0] r;
    unique case (p)
      2'b00: r = 2'b10;
      2'b01: r = 2'b00;
      2'b11: r = 2'b01;
      default: r = 2'b11;
    endcase
    return r;
  endfunction

  // Q4.28 -> Q1.15, ties away from zero, saturating
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic [32:0] mag;
    logic [32:0] q;
    logic signed [15:0] r;
    mag = v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
    q   = (mag + 33'd4096) >> 13;
    if (v[31]) begin
      r = (q > 33'd32768) ? -16'sd32768 : 16'(-q);
    end else begin
      r = (q > 33'd32767) ? 16'sd32767 : 16'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/qoi_front.sv
// ----------------------------------------------------------------------------
// qoi_front
// Accepts input beats, classifies the command and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      command,
  input  wire logic            phase_a,
  input  wire logic            phase_b,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output qoi_pkg::entry_t      q_entry
);

  qoi_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  qoi_pkg::entry_t incoming;
  logic       push;
  logic       pop;

  always_comb begin
    incoming.phase = {phase_a, phase_b};
    unique case (command)
      qoi_pkg::CMD_RIGHT:  incoming.kind = qoi_pkg::KIND_RIGHT;
      qoi_pkg::CMD_LEFT:   incoming.kind = qoi_pkg::KIND_LEFT;
      qoi_pkg::CMD_UPDATE: incoming.kind = qoi_pkg::KIND_UPDATE;
      default:             incoming.kind = qoi_pkg::KIND_NOP;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

>>> hdl/qoi_div.sv
// ----------------------------------------------------------------------------
// qoi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [qoi_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [qoi_pkg::DIV_DEN_W-1:0]    den,
  output logic                                  done,
  output logic [qoi_pkg::DIV_NUM_W-1:0]         quo
);

  localparam int NW = qoi_pkg::DIV_NUM_W;
  localparam int DW = qoi_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/qoi_cordic.sv
// ----------------------------------------------------------------------------
// qoi_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, Q4.28.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_cordic #(
  parameter int CORDIC_STEPS = qoi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [31:0]      sin_out,
  output logic signed [31:0]      cos_out
);

  localparam int CW = $clog2(CORDIC_STEPS);

  logic               busy;
  logic [CW-1:0]      step;
  logic signed [31:0] z;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] ang;

  assign dx  = sin_out >>> step;
  assign dy  = cos_out >>> step;
  assign ang = qoi_pkg::atan_q28(5'(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cos_out <= qoi_pkg::GAIN_Q28;
      sin_out <= '0;
      z       <= angle;
    end else if (busy) begin
      if (!z[31]) begin
        cos_out <= cos_out - dx;
        sin_out <= sin_out + dy;
        z       <= z - ang;
      end else begin
        cos_out <= cos_out + dx;
        sin_out <= sin_out - dy;
        z       <= z + ang;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/qoi_core.sv
// ----------------------------------------------------------------------------
// qoi_core
// Back end: decoder state, odometry sequencer, pose and trig registers.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_core #(
  parameter int CORDIC_STEPS  = qoi_pkg::CORDIC_STEPS_DEF,
  parameter int INTERVAL_BITS = qoi_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire qoi_pkg::entry_t q_entry,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output qoi_pkg::result_t     res
);

  localparam int IB = INTERVAL_BITS;
  localparam logic signed [IB-1:0] IV_MAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] IV_MIN = {1'b1, {(IB-1){1'b0}}};
  // 2^31 mod 2*pi (Q4.28): folding weight of the bits above bit 30
  localparam logic [28:0] FOLD_C = 29'd460853934;

  qoi_pkg::state_t state, state_next;

  logic [15:0] radius, base, ticks;
  logic [15:0] base_eff, ticks_eff;

  logic [1:0]           r_prev, l_prev;
  logic signed [IB-1:0] r_int, l_int;
  logic [31:0]          r_run, l_run;
  logic [15:0]          r_bad, l_bad;
  logic signed [31:0]   x_acc, y_acc, theta;
  logic signed [31:0]   s_q, c_q;

  qoi_pkg::entry_t ent;
  logic            wsel;
  logic            dneg;
  logic [47:0]     numer;
  logic [78:0]     acc;
  logic [30:0]     kbits;
  logic [4:0]      mcnt;
  logic signed [31:0] dr, dl, dmean, sn, cs;
  logic signed [63:0] dth, p_sc, p_cc, p_ss, px, py;

  // heading wrap: modular fold of the angle magnitude
  logic [63:0] fold;
  logic [61:0] fold_prod;
  logic        fold_done;
  logic [30:0] wrap_rem;

  // combinational datapath terms
  logic signed [IB-1:0] iv;
  logic signed [32:0]   iv_ext;
  logic [31:0]          iv_mag;
  logic signed [32:0]   ddiff;
  logic [32:0]          ddiff_mag;
  logic signed [63:0]   u;
  logic [63:0]          u_mag;
  logic [31:0]          wrem;
  logic signed [31:0]   wth;
  logic signed [32:0]   tsum;
  logic signed [32:0]   tfold;
  logic signed [31:0]   dsat;
  logic signed [63:0]   trig_diff;
  logic signed [32:0]   dsum;

  logic        div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;

  logic               cor_start;
  logic               cor_done;
  logic signed [31:0] cor_sin, cor_cos;

  qoi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  qoi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (theta >>> 1),
    .done    (cor_done),
    .sin_out (cor_sin),
    .cos_out (cor_cos)
  );

  assign base_eff  = (base == 16'd0) ? 16'd1 : base;
  assign ticks_eff = (ticks == 16'd0) ? 16'd1 : ticks;

  assign fold_prod = 62'(fold[63:31]) * 62'(FOLD_C);
  assign fold_done = (fold[63:31] == '0);
  assign wrap_rem  = (fold[30:0] >= qoi_pkg::TWO_PI_Q28) ?
                     fold[30:0] - qoi_pkg::TWO_PI_Q28 : fold[30:0];

  always_comb begin
    iv        = wsel ? l_int : r_int;
    iv_ext    = 33'(iv);
    iv_mag    = iv_ext[32] ? 32'(-iv_ext) : iv_ext[31:0];
    ddiff     = 33'(dr) - 33'(dl);
    ddiff_mag = ddiff[32] ? 33'(-ddiff) : 33'(ddiff);
    u         = dth + 64'(qoi_pkg::PI_Q28);
    u_mag     = u[63] ? 64'(-u) : 64'(u);
    // floor modulo of a negative value
    if (u[63] && wrap_rem != 31'd0) begin
      wrem = 32'(qoi_pkg::TWO_PI_Q28) - 32'(wrap_rem);
    end else begin
      wrem = 32'(wrap_rem);
    end
    wth  = $signed(wrem) - qoi_pkg::PI_Q28;
    tsum = 33'(theta) + 33'(wth);
    if (tsum >= 33'(qoi_pkg::PI_Q28)) begin
      tfold = tsum - 33'(qoi_pkg::TWO_PI_Q28);
    end else if (tsum < -33'(qoi_pkg::PI_Q28)) begin
      tfold = tsum + 33'(qoi_pkg::TWO_PI_Q28);
    end else begin
      tfold = tsum;
    end
    // saturate the wheel distance to 32 bits
    if (!dneg) begin
      dsat = (div_quo[63:31] != '0) ? 32'sh7FFFFFFF : $signed(div_quo[31:0]);
    end else begin
      dsat = (div_quo > 64'h80000000) ? 32'sh80000000 : $signed(-div_quo[31:0]);
    end
    trig_diff = p_cc - p_ss;
    dsum      = 33'(dl) + 33'(dr);
  end

  always_comb begin
    unique case (state)
      qoi_pkg::S_DTH: begin
        div_num = (64'(ddiff_mag) << 28) + 64'(base_eff >> 1);
        div_den = 32'(base_eff);
      end
      default: begin
        div_num = {13'd0, acc[78:28]} + 64'(ticks_eff >> 1);
        div_den = 32'(ticks_eff);
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      qoi_pkg::S_INIT:      state_next = qoi_pkg::S_INIT_WAIT;
      qoi_pkg::S_INIT_WAIT: if (cor_done) state_next = qoi_pkg::S_IDLE;
      qoi_pkg::S_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.kind)
            qoi_pkg::KIND_UPDATE: state_next = qoi_pkg::S_MAG;
            qoi_pkg::KIND_NOP:    state_next = qoi_pkg::S_OUT;
            default:              state_next = qoi_pkg::S_ENC;
          endcase
        end
      end
      qoi_pkg::S_ENC:       state_next = qoi_pkg::S_OUT;
      qoi_pkg::S_MAG:       state_next = qoi_pkg::S_MUL;
      qoi_pkg::S_MUL:       if (mcnt == 5'd30) state_next = qoi_pkg::S_DDIV;
      qoi_pkg::S_DDIV:      state_next = qoi_pkg::S_DDIV_WAIT;
      qoi_pkg::S_DDIV_WAIT: begin
        if (div_done) begin
          state_next = wsel ? qoi_pkg::S_DTH : qoi_pkg::S_MAG;
        end
      end
      qoi_pkg::S_DTH:       state_next = qoi_pkg::S_DTH_WAIT;
      qoi_pkg::S_DTH_WAIT:  if (div_done) state_next = qoi_pkg::S_WRAP;
      qoi_pkg::S_WRAP:      state_next = qoi_pkg::S_WRAP_WAIT;
      qoi_pkg::S_WRAP_WAIT: if (fold_done) state_next = qoi_pkg::S_COR;
      qoi_pkg::S_COR:       state_next = qoi_pkg::S_COR_WAIT;
      qoi_pkg::S_COR_WAIT:  if (cor_done) state_next = qoi_pkg::S_PSC;
      qoi_pkg::S_PSC:       state_next = qoi_pkg::S_PCC;
      qoi_pkg::S_PCC:       state_next = qoi_pkg::S_PSS;
      qoi_pkg::S_PSS:       state_next = qoi_pkg::S_TRIG;
      qoi_pkg::S_TRIG:      state_next = qoi_pkg::S_PX;
      qoi_pkg::S_PX:        state_next = qoi_pkg::S_PY;
      qoi_pkg::S_PY:        state_next = qoi_pkg::S_ACC;
      qoi_pkg::S_ACC:       state_next = qoi_pkg::S_OUT;
      qoi_pkg::S_OUT:       if (res_ready) state_next = qoi_pkg::S_IDLE;
      default:              state_next = qoi_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready   = (state == qoi_pkg::S_IDLE);
    res_valid = (state == qoi_pkg::S_OUT);
    div_start = (state == qoi_pkg::S_DDIV) || (state == qoi_pkg::S_DTH);
    cor_start = (state == qoi_pkg::S_INIT) || (state == qoi_pkg::S_COR);
  end

  always_comb begin
    res.pos_x        = x_acc;
    res.pos_y        = y_acc;
    res.heading      = theta[30:0];
    res.quat_z       = qoi_pkg::to_q15(s_q);
    res.quat_w       = qoi_pkg::to_q15(c_q);
    res.right_total  = r_run;
    res.left_total   = l_run;
    res.right_errors = r_bad;
    res.left_errors  = l_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= qoi_pkg::S_INIT;
      radius <= qoi_pkg::RADIUS_RST;
      base   <= qoi_pkg::BASE_RST;
      ticks  <= qoi_pkg::TICKS_RST;
      r_prev <= '0;
      l_prev <= '0;
      r_int  <= '0;
      l_int  <= '0;
      r_run  <= '0;
      l_run  <= '0;
      r_bad  <= '0;
      l_bad  <= '0;
      x_acc  <= '0;
      y_acc  <= '0;
      theta  <= '0;
      wsel   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          qoi_pkg::REG_RADIUS: radius <= cfg_data;
          qoi_pkg::REG_BASE:   base   <= cfg_data;
          qoi_pkg::REG_TICKS:  ticks  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        qoi_pkg::S_IDLE: wsel <= 1'b0;
        qoi_pkg::S_ENC: begin
          if (ent.kind == qoi_pkg::KIND_RIGHT) begin
            if (ent.phase == qoi_pkg::gray_fwd(r_prev)) begin
              if (r_int != IV_MAX) r_int <= r_int + IB'(1);
              r_run <= r_run + 32'd1;
            end else if (ent.phase == qoi_pkg::gray_bwd(r_prev)) begin
              if (r_int != IV_MIN) r_int <= r_int - IB'(1);
              r_run <= r_run - 32'd1;
            end else if (r_bad != 16'hFFFF) begin
              r_bad <= r_bad + 16'd1;
            end
            r_prev <= ent.phase;
          end else begin
            if (ent.phase == qoi_pkg::gray_fwd(l_prev)) begin
              if (l_int != IV_MAX) l_int <= l_int + IB'(1);
              l_run <= l_run + 32'd1;
            end else if (ent.phase == qoi_pkg::gray_bwd(l_prev)) begin
              if (l_int != IV_MIN) l_int <= l_int - IB'(1);
              l_run <= l_run - 32'd1;
            end else if (l_bad != 16'hFFFF) begin
              l_bad <= l_bad + 16'd1;
            end
            l_prev <= ent.phase;
          end
        end
        qoi_pkg::S_DDIV_WAIT: if (div_done) wsel <= 1'b1;
        qoi_pkg::S_WRAP_WAIT: if (fold_done) theta <= 32'(tfold);
        qoi_pkg::S_ACC: begin
          x_acc <= x_acc + px[59:28];
          y_acc <= y_acc + py[59:28];
          r_int <= '0;
          l_int <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == qoi_pkg::S_IDLE && q_valid) begin
      ent <= q_entry;
    end
    if ((state == qoi_pkg::S_INIT_WAIT || state == qoi_pkg::S_COR_WAIT) && cor_done) begin
      s_q <= cor_sin;
      c_q <= cor_cos;
    end
    unique case (state)
      qoi_pkg::S_MAG: begin
        numer <= 48'(iv_mag) * 48'(radius);
        dneg  <= iv_ext[32];
        acc   <= '0;
        kbits <= qoi_pkg::TWO_PI_Q28;
        mcnt  <= '0;
      end
      qoi_pkg::S_MUL: begin
        // MSB-first shift-add against the 2*pi constant
        acc   <= (acc << 1) + (kbits[30] ? 79'(numer) : 79'd0);
        kbits <= kbits << 1;
        mcnt  <= mcnt + 5'd1;
      end
      qoi_pkg::S_DDIV_WAIT: begin
        if (div_done) begin
          if (wsel) dl <= dsat;
          else      dr <= dsat;
        end
      end
      qoi_pkg::S_DTH: dneg <= ddiff[32];
      qoi_pkg::S_DTH_WAIT: begin
        if (div_done) dth <= dneg ? -$signed(div_quo) : $signed(div_quo);
      end
      qoi_pkg::S_WRAP: fold <= u_mag;
      qoi_pkg::S_WRAP_WAIT: begin
        // hi * (2^31 mod 2pi) + lo keeps the residue and shrinks the value
        if (!fold_done) fold <= 64'(fold_prod) + 64'(fold[30:0]);
      end
      qoi_pkg::S_PSC: p_sc <= 64'(s_q) * 64'(c_q);
      qoi_pkg::S_PCC: p_cc <= 64'(c_q) * 64'(c_q);
      qoi_pkg::S_PSS: p_ss <= 64'(s_q) * 64'(s_q);
      qoi_pkg::S_TRIG: begin
        sn    <= p_sc[58:27];
        cs    <= trig_diff[59:28];
        dmean <= dsum[32:1];
      end
      qoi_pkg::S_PX: px <= 64'(dmean) * 64'(cs);
      qoi_pkg::S_PY: py <= 64'(dmean) * 64'(sn);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/quadrature_odometry_integrator.sv
// ----------------------------------------------------------------------------
// quadrature_odometry_integrator
// Two quadrature decoders feeding a differential-drive pose integrator.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat content
// s_*      in   tuser: command; tdata: phase_a, phase_b
// m_*      out  tdata: pose, heading, quaternion terms, totals, error counts
// cfg_*    in   write of wheel radius, wheel base, ticks per revolution
//
// Encoder commands pass the back-end states IDLE, ENC and OUT, unknown commands
// IDLE and OUT; each beat also passes the queue and the output register. An
// update runs the bit-serial distance multiply and the shared one-bit-per-cycle
// divider for each wheel, the heading divide, the heading-wrap fold steps, a
// CORDIC rotation and the trig and pose multiplies.
// After reset the back end computes the initial quaternion; the queue takes up
// to two beats meanwhile. A 2-deep queue and the output register let input and
// output stall independently. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_odometry_integrator #(
  parameter int CORDIC_STEPS  = qoi_pkg::CORDIC_STEPS_DEF,
  parameter int INTERVAL_BITS = qoi_pkg::INTERVAL_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // phase_a, phase_b, zero pad
  input  wire logic [1:0]   s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [223:0]      m_tdata,   // pos_x, pos_y, heading, quat_z, quat_w,
                                       // right_total, left_total, right_errors,
                                       // left_errors, zero pad
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  logic             q_valid;
  logic             q_ready;
  qoi_pkg::entry_t  q_entry;
  logic             res_valid;
  logic             res_ready;
  qoi_pkg::result_t res;
  qoi_pkg::result_t out_q;

  qoi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .command  (s_tuser),
    .phase_a  (s_tdata[0]),
    .phase_b  (s_tdata[1]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  qoi_core #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q};

endmodule

`default_nettype wire

>>> tb/sv/tb_quadrature_odometry_integrator.sv
// ----------------------------------------------------------------------------
// tb_quadrature_odometry_integrator
// Self-checking bench for the quadrature odometry integrator. Encoder and
// update commands are driven on the input stream. A scoreboard predicts the
// pose, quaternion terms, totals and error counts for every accepted beat and
// checks each output beat field by field. The run covers several geometry
// settings and idle patterns, invalid phase moves, and a long output
// back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quadrature_odometry_integrator;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  class odo_scoreboard;
    logic [15:0] radius, base, ticks;
    logic [1:0]  prev_phase[2];
    longint      interval[2];
    logic [31:0] running[2];
    int unsigned bad[2];
    logic [31:0] x_pos, y_pos;
    longint      theta;
    qoi_pkg::result_t pending[$];
    int          fails;

    function new();
      radius = qoi_pkg::RADIUS_RST; base = qoi_pkg::BASE_RST; ticks = qoi_pkg::TICKS_RST;
      prev_phase = '{2'b00, 2'b00};
      interval = '{0, 0};
      running = '{0, 0};
      bad = '{0, 0};
      x_pos = 0; y_pos = 0; theta = 0; fails = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        qoi_pkg::REG_RADIUS: radius = val;
        qoi_pkg::REG_BASE:   base = val;
        qoi_pkg::REG_TICKS:  ticks = val;
        default: ;
      endcase
    endfunction

    function logic [1:0] next_up(logic [1:0] p);
      case (p)
        2'b00: return 2'b01;
        2'b01: return 2'b11;
        2'b11: return 2'b10;
        default: return 2'b00;
      endcase
    endfunction

    function logic [1:0] next_down(logic [1:0] p);
      case (p)
        2'b00: return 2'b10;
        2'b01: return 2'b00;
        2'b11: return 2'b01;
        default: return 2'b11;
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    // ticks to Q16.16 meters, sign-magnitude rounding, saturating
    function longint travel(longint cnt);
      logic [63:0] tk, mag, numer, a, b, t;
      longint d;
      tk = (ticks == 0) ? 64'd1 : 64'(ticks);
      mag = (cnt < 0) ? 64'(-cnt) : 64'(cnt);
      numer = mag * 64'(radius);
      a = (numer >> 24) * 64'(qoi_pkg::TWO_PI_Q28);
      b = (numer & 64'hFFFFFF) * 64'(qoi_pkg::TWO_PI_Q28);
      t = (a >> 4) + ((((a & 64'd15) << 24) + b) >> 28);
      d = longint'((t + tk / 2) / tk);
      if (cnt < 0) d = -d;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      return d;
    endfunction

    function longint wrap_pi(longint v);
      longint two_pi, r;
      two_pi = 2 * longint'(qoi_pkg::PI_Q28);
      r = (v + longint'(qoi_pkg::PI_Q28)) % two_pi;
      if (r < 0) r += two_pi;
      return r - longint'(qoi_pkg::PI_Q28);
    endfunction

    function void rotate(longint z, output longint s, output longint c);
      longint atan_tab[30] = '{210828714, 124459457, 65760959, 33381290,
        16755422, 8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};
      longint cx, cy, dx, dy;
      cx = longint'(qoi_pkg::GAIN_Q28);
      cy = 0;
      for (int i = 0; i < qoi_pkg::CORDIC_STEPS_DEF && i < 30; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= atan_tab[i];
        end else begin
          cx += dx; cy -= dy; z += atan_tab[i];
        end
      end
      s = cy;
      c = cx;
    endfunction

    function logic [15:0] half_q15(longint v);
      longint r;
      r = round_div(v, 8192);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void accept(logic [1:0] cmd, logic [1:0] ph);
      longint dr, dl, bs, mean_d, dth, s, c, sn, cs;
      qoi_pkg::result_t r;
      case (cmd)
        qoi_pkg::CMD_RIGHT, qoi_pkg::CMD_LEFT: begin
          if (ph == next_up(prev_phase[cmd])) begin
            if (interval[cmd] < 32767) interval[cmd]++;
            running[cmd] += 1;
          end else if (ph == next_down(prev_phase[cmd])) begin
            if (interval[cmd] > -32768) interval[cmd]--;
            running[cmd] -= 1;
          end else if (bad[cmd] < 65535) begin
            bad[cmd]++;
          end
          prev_phase[cmd] = ph;
        end
        qoi_pkg::CMD_UPDATE: begin
          dr = travel(interval[qoi_pkg::CMD_RIGHT]);
          dl = travel(interval[qoi_pkg::CMD_LEFT]);
          bs = (base == 0) ? 1 : longint'(base);
          mean_d = (dl + dr) >>> 1;
          dth = round_div((dr - dl) * (64'sd1 << 28), bs);
          theta = wrap_pi(theta + wrap_pi(dth));
          rotate(theta >>> 1, s, c);
          sn = (2 * s * c) >>> 28;
          cs = (c * c - s * s) >>> 28;
          x_pos += 32'((mean_d * cs) >>> 28);
          y_pos += 32'((mean_d * sn) >>> 28);
          interval = '{0, 0};
        end
        default: ;
      endcase
      rotate(theta >>> 1, s, c);
      r.pos_x = x_pos;
      r.pos_y = y_pos;
      r.heading = theta[30:0];
      r.quat_z = half_q15(s);
      r.quat_w = half_q15(c);
      r.right_total = running[qoi_pkg::CMD_RIGHT];
      r.left_total = running[qoi_pkg::CMD_LEFT];
      r.right_errors = bad[qoi_pkg::CMD_RIGHT][15:0];
      r.left_errors = bad[qoi_pkg::CMD_LEFT][15:0];
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $error("%s: expected %h, got %h", name, e, g);
        fails++;
      end
    endfunction

    function void check(logic [223:0] beat);
      qoi_pkg::result_t g, e;
      g = qoi_pkg::result_t'(beat[222:0]);
      if (pending.size() == 0) begin
        $error("output beat with nothing expected");
        fails++;
        return;
      end
      e = pending.pop_front();
      cmp("pos_x", e.pos_x, g.pos_x);
      cmp("pos_y", e.pos_y, g.pos_y);
      cmp("heading", 32'(e.heading), 32'(g.heading));
      cmp("quat_z", 32'(e.quat_z), 32'(g.quat_z));
      cmp("quat_w", 32'(e.quat_w), 32'(g.quat_w));
      cmp("right_total", e.right_total, g.right_total);
      cmp("left_total", e.left_total, g.left_total);
      cmp("right_errors", 32'(e.right_errors), 32'(g.right_errors));
      cmp("left_errors", 32'(e.left_errors), 32'(g.left_errors));
      if (beat[223] !== 1'b0) begin
        $error("pad: expected 0, got %b", beat[223]);
        fails++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [223:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  odo_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit wheel_dir[2] = '{1'b1, 1'b0};

  quadrature_odometry_integrator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check(m_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** quadrature_odometry_integrator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat; called and returns at a falling edge
  task automatic send(logic [1:0] cmd, logic [1:0] ph);
    if ($urandom_range(0, 99) < send_idle_pct) repeat ($urandom_range(1, 4)) @(negedge clk);
    s_tuser = cmd;
    s_tdata = {6'd0, ph[0], ph[1]};  // bit0 phase_a, bit1 phase_b
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.accept(cmd, ph);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic step_wheel(logic [1:0] w, bit up);
    send(w, up ? sb.next_up(sb.prev_phase[w]) : sb.next_down(sb.prev_phase[w]));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(logic [15:0] r, logic [15:0] b, logic [15:0] t);
    write_reg(qoi_pkg::REG_RADIUS, r);
    write_reg(qoi_pkg::REG_BASE, b);
    write_reg(qoi_pkg::REG_TICKS, t);
  endtask

  task automatic random_beat();
    int pick;
    logic [1:0] w;
    pick = $urandom_range(0, 99);
    w = $urandom_range(0, 1) ? qoi_pkg::CMD_LEFT : qoi_pkg::CMD_RIGHT;
    if ($urandom_range(0, 29) == 0) wheel_dir[w] = ~wheel_dir[w];
    if (pick < 88) begin
      step_wheel(w, $urandom_range(0, 9) < 8 ? wheel_dir[w] : ~wheel_dir[w]);
    end else if (pick < 95) begin
      send(qoi_pkg::CMD_UPDATE, 2'($urandom));
    end else if (pick < 98) begin
      send(w, 2'($urandom));
    end else begin
      send(qoi_pkg::KIND_NOP, 2'($urandom));
    end
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) random_beat();
    send(qoi_pkg::CMD_UPDATE, 2'b00);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero update, full Gray cycles both ways, invalid moves, no-op
    send(qoi_pkg::CMD_UPDATE, 2'b00);
    send(qoi_pkg::CMD_RIGHT, 2'b01);
    send(qoi_pkg::CMD_RIGHT, 2'b11);
    send(qoi_pkg::CMD_RIGHT, 2'b10);
    send(qoi_pkg::CMD_RIGHT, 2'b00);
    send(qoi_pkg::CMD_RIGHT, 2'b01);
    send(qoi_pkg::CMD_LEFT, 2'b10);
    send(qoi_pkg::CMD_LEFT, 2'b11);
    send(qoi_pkg::CMD_LEFT, 2'b01);
    send(qoi_pkg::CMD_LEFT, 2'b00);
    send(qoi_pkg::CMD_LEFT, 2'b00);   // repeated phase
    send(qoi_pkg::CMD_LEFT, 2'b11);   // skipped state
    send(qoi_pkg::CMD_RIGHT, 2'b10);  // skipped state
    send(qoi_pkg::KIND_NOP, 2'b11);
    send(qoi_pkg::KIND_NOP, 2'b00);
    send(qoi_pkg::CMD_UPDATE, 2'b11);
    send(qoi_pkg::CMD_LEFT, 2'b01);
    send(qoi_pkg::CMD_LEFT, 2'b11);
    send(qoi_pkg::CMD_UPDATE, 2'b01);
    drain();

    random_phase(300, 0, 0);

    set_geometry(16'hFFFF, 16'd1, 16'd1);
    write_reg(REG_UNMAPPED, 16'hFFFF);  // unmapped index, must be ignored
    random_phase(300, 57, 0);

    set_geometry(16'd1, 16'hFFFF, 16'hFFFF);
    random_phase(300, 0, 57);

    set_geometry(16'd0, 16'd0, 16'd0);
    random_phase(300, 11, 11);

    // output held off while input keeps coming
    set_geometry(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
    hold_left = 600;
    random_phase(300, 0, 0);

    set_geometry(qoi_pkg::RADIUS_RST, qoi_pkg::BASE_RST, qoi_pkg::TICKS_RST);
    random_phase(300, 57, 57);

    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("** quadrature_odometry_integrator: PASSED **");
    end else begin
      $display("** quadrature_odometry_integrator: FAILED **");
    end
    $finish;
  end

endmodule
